FILE: rtl/core/sgv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgv_pkg
// Shared widths, limits and helpers for the staggered grid vorticity core.
// ----------------------------------------------------------------------------
package sgv_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int LEN_W       = COL_W + 1;
  localparam int DATA_W      = 32;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int FRAC_BITS   = 16;
  localparam int QUO_W       = DIFF_W + FRAC_BITS;
  localparam int QS_W        = QUO_W + 1;
  localparam int W_W         = QS_W + 1;
  localparam int DIV_STEPS   = QUO_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(MAX_COLUMNS);
  localparam logic [LEN_W-1:0] ROW_LENGTH_MIN   = LEN_W'(2);

  typedef logic signed [DIFF_W-1:0] diff_t;

  // magnitude of a signed difference, most negative value included
  function automatic logic [DIFF_W-1:0] mag(input diff_t a);
    logic [DIFF_W-1:0] r;
    r = a[DIFF_W-1] ? (DIFF_W'(0) - DIFF_W'(a)) : DIFF_W'(a);
    return r;
  endfunction

endpackage

FILE: rtl/core/staggered_grid_vorticity_2d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staggered_grid_vorticity_2d_core
// Backward-difference z vorticity of a raster-ordered Q16.16 velocity field.
// ----------------------------------------------------------------------------
// sequence: a point without result passes S_READ and goes back to S_IDLE;
//   a result with nonzero spacing runs S_DIV, S_FIX1, S_DIV, S_FIX2, S_SUB, S_OUT
// one point at a time: in_ready_o is high only in S_IDLE; the shared radix-2
//   divider runs both 49-step quotients, one quotient bit per cycle in S_DIV
// reset: async active low; clears control and station history, row length
//   back to 1024; the line buffer holds no reset value
module staggered_grid_vorticity_2d_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sgv_pkg::LEN_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sgv_pkg::DATA_W-1:0]   u_value_i,
  input  logic signed [sgv_pkg::DATA_W-1:0]   v_value_i,
  input  logic signed [sgv_pkg::DATA_W-1:0]   x_station_i,
  input  logic signed [sgv_pkg::DATA_W-1:0]   y_station_i,
  input  logic                                frame_start_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sgv_pkg::DATA_W-1:0]   vorticity_o,
  output logic                                spacing_error_o,
  output logic                                row_end_o
);
  import sgv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_FIX1,
    S_FIX2,
    S_SUB,
    S_OUT
  } state_e;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q;
  logic                pass_q;
  logic                out_valid_q;
  logic [LEN_W-1:0]    row_length_q;
  logic [COL_W-1:0]    col_idx_q;
  logic                first_q;
  logic [DATA_W-1:0]   prev_v_q;
  logic [DATA_W-1:0]   prev_x_q;
  logic [DATA_W-1:0]   prev_row_y_q;
  logic [DATA_W-1:0]   this_row_y_q;

  // per-point payload
  logic [DATA_W-1:0]   u_q;
  logic [COL_W-1:0]    col_q;
  logic                produce_q;
  logic                row_end_q;
  diff_t               dx_q, dy_q, dv_q, du_q;
  logic [DATA_W-1:0]   rd_data_q;

  // divider
  logic [DIFF_W-1:0]   rem_q;
  logic [QUO_W-1:0]    quo_q;
  logic [DIFF_W-1:0]   div_q;
  logic                neg_q;
  logic signed [QS_W-1:0] q1_q, q2_q;

  logic [DATA_W-1:0]   wres_q;
  logic                err_q;
  logic [DATA_W-1:0]   vort_out_q;
  logic                err_out_q;
  logic                row_end_out_q;

  logic [DATA_W-1:0]   line_mem [MAX_COLUMNS];

  logic                in_fire;
  logic                out_load;
  logic [LEN_W-1:0]    len_eff;
  logic [COL_W-1:0]    col_start;
  logic                first_start;
  logic [LEN_W-1:0]    col_inc;
  logic                wraps;
  logic                produce;
  logic [DIFF_W+1:0]   trial;
  logic                fits;
  logic [DIFF_W-1:0]   rem_step;
  logic [QUO_W-1:0]    quo_step;
  logic signed [QS_W-1:0] q_signed;
  logic signed [W_W-1:0]  w_full;
  logic [DATA_W-1:0]   w_sat;
  logic                w_ovf;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // clamp row length into 2..MAX_COLUMNS
  always_comb begin
    if (row_length_q < ROW_LENGTH_MIN) begin
      len_eff = ROW_LENGTH_MIN;
    end else if (row_length_q > LEN_W'(MAX_COLUMNS)) begin
      len_eff = LEN_W'(MAX_COLUMNS);
    end else begin
      len_eff = row_length_q;
    end
  end

  always_comb begin
    if (frame_start_i) begin
      col_start   = '0;
      first_start = 1'b1;
    end else if ({1'b0, col_idx_q} >= len_eff) begin
      // row length shrunk under us: start a fresh row
      col_start   = '0;
      first_start = 1'b0;
    end else begin
      col_start   = col_idx_q;
      first_start = first_q;
    end
    col_inc = {1'b0, col_start} + LEN_W'(1);
    wraps   = (col_inc >= len_eff);
    produce = !first_start && (col_start != '0);
  end

  // one restoring step of the shared divider
  always_comb begin
    trial    = {1'b0, rem_q, quo_q[QUO_W-1]} - {2'b00, div_q};
    fits     = !trial[DIFF_W+1];
    rem_step = fits ? trial[DIFF_W-1:0] : {rem_q[DIFF_W-2:0], quo_q[QUO_W-1]};
    quo_step = {quo_q[QUO_W-2:0], fits};
    q_signed = neg_q ? (QS_W'(0) - $signed({1'b0, quo_q})) : $signed({1'b0, quo_q});
  end

  always_comb begin
    w_full = W_W'(q1_q) - W_W'(q2_q);
    w_ovf  = (w_full[W_W-1:DATA_W-1] != '0) && (w_full[W_W-1:DATA_W-1] != '1);
    if (!w_ovf) begin
      w_sat = w_full[DATA_W-1:0];
    end else if (w_full[W_W-1]) begin
      w_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      w_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (!produce_q) begin
          state_d = S_IDLE;
        end else if (dx_q == '0 || dy_q == '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = pass_q ? S_FIX2 : S_FIX1;
        end
      end
      S_FIX1:  state_d = S_DIV;
      S_FIX2:  state_d = S_SUB;
      S_SUB:   state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= '0;
      pass_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      row_length_q <= ROW_LENGTH_RESET;
      col_idx_q    <= '0;
      first_q      <= 1'b1;
      prev_v_q     <= '0;
      prev_x_q     <= '0;
      prev_row_y_q <= '0;
      this_row_y_q <= '0;
      produce_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        row_length_q <= cfg_data_i;
      end
      if (in_fire) begin
        if (col_start == '0) begin
          if (!first_start) begin
            prev_row_y_q <= this_row_y_q;
          end
          this_row_y_q <= y_station_i;
        end
        prev_v_q  <= v_value_i;
        prev_x_q  <= x_station_i;
        col_idx_q <= wraps ? '0 : col_inc[COL_W-1:0];
        first_q   <= wraps ? 1'b0 : first_start;
        produce_q <= produce;
      end
      case (state_q)
        S_READ: begin
          step_q <= '0;
          pass_q <= 1'b0;
        end
        S_DIV:   step_q <= step_q + STEP_W'(1);
        S_FIX1: begin
          step_q <= '0;
          pass_q <= 1'b1;
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      u_q       <= u_value_i;
      col_q     <= col_start;
      row_end_q <= wraps;
      dx_q      <= {x_station_i[DATA_W-1], x_station_i}
                   - {prev_x_q[DATA_W-1], prev_x_q};
      dy_q      <= {y_station_i[DATA_W-1], y_station_i}
                   - {prev_row_y_q[DATA_W-1], prev_row_y_q};
      dv_q      <= {v_value_i[DATA_W-1], v_value_i}
                   - {prev_v_q[DATA_W-1], prev_v_q};
    end
    case (state_q)
      S_READ: begin
        du_q  <= {u_q[DATA_W-1], u_q} - {rd_data_q[DATA_W-1], rd_data_q};
        rem_q <= '0;
        quo_q <= {mag(dv_q), {FRAC_BITS{1'b0}}};
        div_q <= mag(dx_q);
        neg_q <= dv_q[DIFF_W-1] ^ dx_q[DIFF_W-1];
        if (dx_q == '0 || dy_q == '0) begin
          wres_q <= '0;
          err_q  <= 1'b1;
        end else begin
          err_q  <= 1'b0;
        end
      end
      S_DIV: begin
        rem_q <= rem_step;
        quo_q <= quo_step;
      end
      S_FIX1: begin
        q1_q  <= q_signed;
        rem_q <= '0;
        quo_q <= {mag(du_q), {FRAC_BITS{1'b0}}};
        div_q <= mag(dy_q);
        neg_q <= du_q[DIFF_W-1] ^ dy_q[DIFF_W-1];
      end
      S_FIX2:  q2_q   <= q_signed;
      S_SUB:   wres_q <= w_sat;
      default: ;
    endcase
    if (out_load) begin
      vort_out_q    <= wres_q;
      err_out_q     <= err_q;
      row_end_out_q <= row_end_q;
    end
  end

  // line buffer of last-row u, one read and one write port
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_data_q <= line_mem[col_start];
    end
    if (state_q == S_READ) begin
      line_mem[col_q] <= u_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vorticity_o     = vort_out_q;
  assign spacing_error_o = err_out_q;
  assign row_end_o       = row_end_out_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && spacing_error_o |-> vorticity_o == '0)
    else $error("spacing error beat carries nonzero vorticity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("core ready again right after taking a beat");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("output beat raised outside of the output state");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && step_q == STEP_W'(DIV_STEPS - 1) |=>
      state_q == S_FIX1 || state_q == S_FIX2)
    else $error("divider ran past its step count");

endmodule
